// ===== hdl/i2ctdc_pkg.sv =====
// Package for the I2C SCL timing divider calculation block.
// Holds field widths, command and status types, error codes and the timing tables.
// No dependencies.
package i2ctdc_pkg;

    localparam int MHZ_W  = 10;
    localparam int HZ_W   = 20;
    localparam int TIME_W = 12;
    localparam int CTRL_W = 16;
    localparam int DIV_W  = 32;
    localparam int ERR_W  = 3;
    localparam int W      = 32;

    localparam logic [W-1:0] HZ_STD_MAX   = 32'd100000;
    localparam logic [W-1:0] HZ_FAST_MAX  = 32'd400000;
    localparam logic [W-1:0] HZ_FPLUS_MAX = 32'd1000000;
    localparam logic [W-1:0] NS_PER_DIV   = 32'd8000;
    localparam logic [W-1:0] CLK_PER_MHZ  = 32'd125000;
    localparam logic [W-1:0] DIV_LIMIT    = 32'h10000;
    localparam logic [W-1:0] NS_PER_US    = 32'd1000;
    localparam logic [W-1:0] SETUP_LIMIT  = 32'd4;
    localparam logic [2:0]   UPD_FIRST    = 3'd5;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_RATE  = 3'd1,
        ERR_OVF   = 3'd2,
        ERR_SETUP = 3'd3,
        ERR_HOLD  = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        SEL_HIGH  = 3'd0,
        SEL_LOW   = 3'd1,
        SEL_TOTAL = 3'd2,
        SEL_RATE  = 3'd3,
        SEL_START = 3'd4,
        SEL_STOP  = 3'd5,
        SEL_SETUP = 3'd6,
        SEL_HOLD  = 3'd7
    } sel_t;

    typedef enum logic [1:0] {
        MODE_STD   = 2'd0,
        MODE_FAST  = 2'd1,
        MODE_FPLUS = 2'd2
    } mode_t;

    typedef struct packed {
        logic [12:0] scl_low;
        logic [12:0] scl_high;
        logic [12:0] data_setup;
        logic [12:0] data_hold;
        logic [12:0] start_setup;
        logic [12:0] stop_setup;
    } timing_t;

    typedef struct packed {
        logic start;
        sel_t sel;
        logic adjust;
        logic v_dec;
        logic fin;
        err_t err;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic bad_rate;
        logic rate_ok;
        logic ovf;
        logic setup_err;
        logic fit;
        logic v_zero;
        logic out_free;
    } status_t;

    function automatic timing_t timing_of(input mode_t mode);
        timing_t t;
        unique case (mode)
            MODE_STD:   t = '{13'd4700, 13'd4000, 13'd250, 13'd3450, 13'd4700, 13'd4000};
            MODE_FAST:  t = '{13'd1300, 13'd600, 13'd100, 13'd900, 13'd600, 13'd600};
            default:    t = '{13'd500, 13'd260, 13'd50, 13'd400, 13'd260, 13'd260};
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/i2ctdc_if.sv =====
// Channel interfaces for the I2C SCL timing divider calculation block.
// Depends on i2ctdc_pkg for the field widths.
interface i2ctdc_req_if;
    logic                              valid;
    logic                              ready;
    logic [i2ctdc_pkg::MHZ_W-1:0]      controller_mhz;
    logic [i2ctdc_pkg::HZ_W-1:0]       target_hz;
    logic [i2ctdc_pkg::TIME_W-1:0]     rise_time_ns;
    logic [i2ctdc_pkg::TIME_W-1:0]     fall_time_ns;

    modport source (output valid, controller_mhz, target_hz, rise_time_ns, fall_time_ns,
                    input ready);
    modport sink (input valid, controller_mhz, target_hz, rise_time_ns, fall_time_ns,
                  output ready);
endinterface

interface i2ctdc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [i2ctdc_pkg::CTRL_W-1:0]     control_word;
    logic [i2ctdc_pkg::DIV_W-1:0]      divider_word;
    logic [i2ctdc_pkg::HZ_W-1:0]       effective_hz;
    logic                              rate_limited;
    logic [i2ctdc_pkg::ERR_W-1:0]      error_code;

    modport source (output valid, control_word, divider_word, effective_hz, rate_limited,
                    error_code, input ready);
    modport sink (input valid, control_word, divider_word, effective_hz, rate_limited,
                  error_code, output ready);
endinterface

// ===== hdl/i2c_timing_divider_calc_core.sv =====
// Top level of the I2C SCL timing divider calculation block.
// Depends on i2ctdc_pkg, the channel interfaces, i2ctdc_ctrl and i2ctdc_dpath.
//
//   Channel  Role  Payload
//   req      sink  controller_mhz, target_hz, rise_time_ns, fall_time_ns
//   rsp      src   control_word, divider_word, effective_hz, rate_limited, error_code
//
// One item at a time. An item takes up to 18 divisions on the shared bit-serial
// divider plus the control states between them; an item with a bad rate runs no
// division and goes straight to its result.
// Reset returns the controller to idle and empties the result register.
// A result waits in its register while rsp is stalled; the next item may already run.
module i2c_timing_divider_calc_core (
    input  logic         clk,
    input  logic         rst_n,
    i2ctdc_req_if.sink   req,
    i2ctdc_rsp_if.source rsp
);
    i2ctdc_pkg::cmd_t    cmd;
    i2ctdc_pkg::status_t status;
    logic                ready;

    assign req.ready = ready;

    i2ctdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (ready),
        .status   (status),
        .cmd      (cmd)
    );

    i2ctdc_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .accept (req.valid && ready),
        .cmd    (cmd),
        .status (status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && ready) |=> !ready)
        else $error("input taken while an item is in progress");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error_code != i2ctdc_pkg::ERR_OK) |->
        (rsp.divider_word == '0 && rsp.effective_hz == '0 && !rsp.rate_limited
         && rsp.control_word == '0))
        else $error("error result carries non-zero fields");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin) |-> !cmd.start)
        else $error("result written while a division starts");
endmodule

// ===== hdl/i2ctdc_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on i2ctdc_pkg for the word width.
module i2ctdc_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [i2ctdc_pkg::W-1:0] dividend,
    input  logic [i2ctdc_pkg::W-1:0] divisor,
    output logic [i2ctdc_pkg::W-1:0] quotient,
    output logic [i2ctdc_pkg::W-1:0] remainder,
    output logic                     done
);
    localparam int CW = $clog2(i2ctdc_pkg::W + 1);

    logic [i2ctdc_pkg::W-1:0] q_reg, q_next;
    logic [i2ctdc_pkg::W-1:0] r_reg, r_next;
    logic [i2ctdc_pkg::W-1:0] b_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     done_reg;
    logic [i2ctdc_pkg::W:0]   trial;

    always_comb
    begin
        trial = {r_reg, q_reg[i2ctdc_pkg::W-1]};
        if (trial >= {1'b0, b_reg})
        begin
            r_next = i2ctdc_pkg::W'(trial - {1'b0, b_reg});
            q_next = {q_reg[i2ctdc_pkg::W-2:0], 1'b1};
        end
        else
        begin
            r_next = trial[i2ctdc_pkg::W-1:0];
            q_next = {q_reg[i2ctdc_pkg::W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(i2ctdc_pkg::W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            b_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;
endmodule

// ===== hdl/i2ctdc_dpath.sv =====
// Datapath: input registers, timing table, operand selection, divider and result register.
// Depends on i2ctdc_pkg, the channel interfaces and i2ctdc_div.
module i2ctdc_dpath (
    input  logic               clk,
    input  logic               rst_n,
    i2ctdc_req_if.sink         req,
    i2ctdc_rsp_if.source       rsp,
    input  logic               accept,
    input  i2ctdc_pkg::cmd_t   cmd,
    output i2ctdc_pkg::status_t status
);
    localparam int W = i2ctdc_pkg::W;

    logic [i2ctdc_pkg::MHZ_W-1:0]  mhz_reg;
    logic [i2ctdc_pkg::TIME_W-1:0] rise_reg;
    logic [i2ctdc_pkg::TIME_W-1:0] fall_reg;
    logic [W-1:0]                  hz_reg;
    i2ctdc_pkg::mode_t             mode_reg;
    logic [W-1:0]                  divh_reg, divl_reg, total_reg;
    logic [W-1:0]                  sstart_reg, sstop_reg, setup_ns_reg, hold_ns_reg;
    logic                          lim_reg;
    logic [2:0]                    v_reg;

    logic                          out_valid_reg;
    logic [i2ctdc_pkg::CTRL_W-1:0] ctrl_out_reg;
    logic [i2ctdc_pkg::DIV_W-1:0]  div_out_reg;
    logic [i2ctdc_pkg::HZ_W-1:0]   hz_out_reg;
    logic                          lim_out_reg;
    logic [i2ctdc_pkg::ERR_W-1:0]  err_out_reg;

    i2ctdc_pkg::timing_t tm;
    logic [W-1:0] mhz32, rise32, fall32, v32, clk_units, sum_div, bonus, hb;
    logic [W-1:0] op_a, op_b, quo, rem, q_fin;
    logic         use_ceil, done;
    i2ctdc_pkg::mode_t mode_in;

    assign tm        = i2ctdc_pkg::timing_of(mode_reg);
    assign mhz32     = W'(mhz_reg);
    assign rise32    = W'(rise_reg);
    assign fall32    = W'(fall_reg);
    assign v32       = W'(v_reg);
    assign clk_units = mhz32 * i2ctdc_pkg::CLK_PER_MHZ;
    assign sum_div   = divh_reg + divl_reg;
    assign bonus     = total_reg - divh_reg - divl_reg;
    assign hb        = bonus >> 1;

    always_comb
    begin
        if (W'(req.target_hz) <= i2ctdc_pkg::HZ_STD_MAX)
        begin
            mode_in = i2ctdc_pkg::MODE_STD;
        end
        else if (W'(req.target_hz) <= i2ctdc_pkg::HZ_FAST_MAX)
        begin
            mode_in = i2ctdc_pkg::MODE_FAST;
        end
        else
        begin
            mode_in = i2ctdc_pkg::MODE_FPLUS;
        end
    end

    always_comb
    begin
        use_ceil = 1'b1;
        unique case (cmd.sel)
            i2ctdc_pkg::SEL_HIGH:
            begin
                op_a = (rise32 + W'(tm.scl_high)) * mhz32;
                op_b = i2ctdc_pkg::NS_PER_DIV;
            end
            i2ctdc_pkg::SEL_LOW:
            begin
                op_a = (fall32 + W'(tm.scl_low)) * mhz32;
                op_b = i2ctdc_pkg::NS_PER_DIV;
            end
            i2ctdc_pkg::SEL_TOTAL:
            begin
                op_a = clk_units;
                op_b = hz_reg;
            end
            i2ctdc_pkg::SEL_RATE:
            begin
                op_a     = clk_units;
                op_b     = sum_div;
                use_ceil = 1'b0;
            end
            i2ctdc_pkg::SEL_START:
            begin
                op_a = mhz32 * (rise32 + W'(tm.start_setup)) - i2ctdc_pkg::NS_PER_US;
                op_b = i2ctdc_pkg::NS_PER_DIV * divh_reg;
            end
            i2ctdc_pkg::SEL_STOP:
            begin
                op_a = mhz32 * (rise32 + W'(tm.stop_setup)) - i2ctdc_pkg::NS_PER_US;
                op_b = i2ctdc_pkg::NS_PER_DIV * divh_reg;
            end
            i2ctdc_pkg::SEL_SETUP:
            begin
                op_a     = ((W'(8) - v32) * divl_reg + W'(1)) * i2ctdc_pkg::NS_PER_US;
                op_b     = mhz32;
                use_ceil = 1'b0;
            end
            default:
            begin
                op_a = (v32 * divl_reg + W'(1)) * i2ctdc_pkg::NS_PER_US;
                op_b = mhz32;
            end
        endcase
    end

    i2ctdc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .dividend  (op_a),
        .divisor   (op_b),
        .quotient  (quo),
        .remainder (rem),
        .done      (done)
    );

    assign q_fin = quo + W'(use_ceil && (rem != '0));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mhz_reg  <= req.controller_mhz;
            rise_reg <= req.rise_time_ns;
            fall_reg <= req.fall_time_ns;
            hz_reg   <= W'(req.target_hz);
            mode_reg <= mode_in;
            lim_reg  <= 1'b0;
            v_reg    <= i2ctdc_pkg::UPD_FIRST;
        end
        else
        begin
            if (cmd.adjust)
            begin
                divh_reg <= divh_reg + hb;
                divl_reg <= divl_reg + (bonus - hb);
            end
            if (cmd.v_dec)
            begin
                v_reg <= v_reg - 3'd1;
            end
            if (done)
            begin
                unique case (cmd.sel)
                    i2ctdc_pkg::SEL_HIGH:  divh_reg <= q_fin;
                    i2ctdc_pkg::SEL_LOW:   divl_reg <= q_fin;
                    i2ctdc_pkg::SEL_TOTAL: total_reg <= q_fin;
                    i2ctdc_pkg::SEL_RATE:
                    begin
                        hz_reg  <= q_fin;
                        lim_reg <= 1'b1;
                    end
                    i2ctdc_pkg::SEL_START: sstart_reg <= q_fin;
                    i2ctdc_pkg::SEL_STOP:  sstop_reg <= q_fin;
                    i2ctdc_pkg::SEL_SETUP: setup_ns_reg <= q_fin;
                    default:               hold_ns_reg <= q_fin;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            err_out_reg <= cmd.err;
            if (cmd.err == i2ctdc_pkg::ERR_OK)
            begin
                ctrl_out_reg <= {sstop_reg[1:0], sstart_reg[1:0], 1'b0, v_reg, 8'd0};
                div_out_reg  <= {divh_reg[15:0] - 16'd1, 16'd0} | (divl_reg - W'(1));
                hz_out_reg   <= hz_reg[i2ctdc_pkg::HZ_W-1:0];
                lim_out_reg  <= lim_reg;
            end
            else
            begin
                ctrl_out_reg <= '0;
                div_out_reg  <= '0;
                hz_out_reg   <= '0;
                lim_out_reg  <= 1'b0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.control_word = ctrl_out_reg;
    assign rsp.divider_word = div_out_reg;
    assign rsp.effective_hz = hz_out_reg;
    assign rsp.rate_limited = lim_out_reg;
    assign rsp.error_code   = err_out_reg;

    assign status.div_done  = done;
    assign status.bad_rate  = (hz_reg == '0) || (hz_reg > i2ctdc_pkg::HZ_FPLUS_MAX)
                              || (mhz_reg == '0);
    assign status.rate_ok   = sum_div < total_reg;
    assign status.ovf       = (divh_reg > i2ctdc_pkg::DIV_LIMIT)
                              || (divl_reg > i2ctdc_pkg::DIV_LIMIT);
    assign status.setup_err = (sstart_reg >= i2ctdc_pkg::SETUP_LIMIT)
                              || (sstop_reg >= i2ctdc_pkg::SETUP_LIMIT);
    assign status.fit       = (hold_ns_reg <= W'(tm.data_hold))
                              && (setup_ns_reg >= W'(tm.data_setup));
    assign status.v_zero    = (v_reg == 3'd0);
    assign status.out_free  = !out_valid_reg || rsp.ready;
endmodule

// ===== hdl/i2ctdc_ctrl.sv =====
// Controller: sequences the divisions, the spare-time split and the error checks.
// Depends on i2ctdc_pkg for the command and status types.
module i2ctdc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2ctdc_pkg::status_t status,
    output i2ctdc_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_START, S_WAIT, S_NEXT, S_ADJ, S_OVF, S_FINISH
    } state_t;

    state_t             state_reg;
    logic               ready_reg;
    i2ctdc_pkg::sel_t   sel_reg;
    i2ctdc_pkg::err_t   err_reg;
    i2ctdc_pkg::cmd_t   cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            sel_reg   <= i2ctdc_pkg::SEL_HIGH;
            err_reg   <= i2ctdc_pkg::ERR_OK;
            cmd_reg   <= '{1'b0, i2ctdc_pkg::SEL_HIGH, 1'b0, 1'b0, 1'b0, i2ctdc_pkg::ERR_OK};
        end
        else
        begin
            cmd_reg.start  <= 1'b0;
            cmd_reg.adjust <= 1'b0;
            cmd_reg.v_dec  <= 1'b0;
            cmd_reg.fin    <= 1'b0;
            cmd_reg.sel    <= sel_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ready_reg && in_valid)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        ready_reg <= 1'b1;
                    end
                end
                S_CHECK:
                begin
                    if (status.bad_rate)
                    begin
                        err_reg   <= i2ctdc_pkg::ERR_RATE;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        sel_reg   <= i2ctdc_pkg::SEL_HIGH;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    cmd_reg.start <= 1'b1;
                    state_reg     <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    state_reg <= S_START;
                    unique case (sel_reg)
                        i2ctdc_pkg::SEL_HIGH:  sel_reg <= i2ctdc_pkg::SEL_LOW;
                        i2ctdc_pkg::SEL_LOW:   sel_reg <= i2ctdc_pkg::SEL_TOTAL;
                        i2ctdc_pkg::SEL_TOTAL:
                        begin
                            if (status.rate_ok)
                            begin
                                cmd_reg.adjust <= 1'b1;
                                state_reg      <= S_ADJ;
                            end
                            else
                            begin
                                sel_reg <= i2ctdc_pkg::SEL_RATE;
                            end
                        end
                        i2ctdc_pkg::SEL_RATE:  state_reg <= S_OVF;
                        i2ctdc_pkg::SEL_START: sel_reg <= i2ctdc_pkg::SEL_STOP;
                        i2ctdc_pkg::SEL_STOP:
                        begin
                            if (status.setup_err)
                            begin
                                err_reg   <= i2ctdc_pkg::ERR_SETUP;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                sel_reg <= i2ctdc_pkg::SEL_SETUP;
                            end
                        end
                        i2ctdc_pkg::SEL_SETUP: sel_reg <= i2ctdc_pkg::SEL_HOLD;
                        default:
                        begin
                            if (status.fit)
                            begin
                                err_reg   <= i2ctdc_pkg::ERR_OK;
                                state_reg <= S_FINISH;
                            end
                            else if (status.v_zero)
                            begin
                                err_reg   <= i2ctdc_pkg::ERR_HOLD;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                cmd_reg.v_dec <= 1'b1;
                                sel_reg       <= i2ctdc_pkg::SEL_SETUP;
                            end
                        end
                    endcase
                end
                S_ADJ:
                begin
                    state_reg <= S_OVF;
                end
                S_OVF:
                begin
                    if (status.ovf)
                    begin
                        err_reg   <= i2ctdc_pkg::ERR_OVF;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        sel_reg   <= i2ctdc_pkg::SEL_START;
                        state_reg <= S_START;
                    end
                end
                default:
                begin
                    if (status.out_free)
                    begin
                        cmd_reg.fin <= 1'b1;
                        cmd_reg.err <= err_reg;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_ready = ready_reg;
    assign cmd      = cmd_reg;
endmodule

// ===== tb/tb.sv =====
// Testbench for the I2C SCL timing divider calculation core.
// Drives parameter items through the request channel and checks every response
// against a predictor of the divider arithmetic. Depends on i2ctdc_pkg and the channel interfaces.
`timescale 1ns / 100ps

module tb;
    localparam int W = i2ctdc_pkg::W;

    typedef struct packed {
        logic [i2ctdc_pkg::CTRL_W-1:0] control_word;
        logic [i2ctdc_pkg::DIV_W-1:0]  divider_word;
        logic [i2ctdc_pkg::HZ_W-1:0]   effective_hz;
        logic                          rate_limited;
        logic [i2ctdc_pkg::ERR_W-1:0]  error_code;
    } timing_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches = 0;
    bit   idle_enable = 1'b1;
    bit   hold_off = 1'b0;
    timing_res_t expected_timings[$];

    i2ctdc_req_if req();
    i2ctdc_rsp_if rsp();

    i2c_timing_divider_calc_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.controller_mhz = '0;
        req.target_hz = '0;
        req.rise_time_ns = '0;
        req.fall_time_ns = '0;
        rsp.ready = 1'b0;
    end

    initial
    begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [W-1:0] div_up(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] q;
        if (b == 0)
            return '1;
        q = a / b;
        if (a % b != 0)
            q = q + 1;
        return q;
    endfunction

    function automatic timing_res_t calc_timing(input logic [9:0] mhz_in,
                                                input logic [19:0] hz_in,
                                                input logic [11:0] rise_in,
                                                input logic [11:0] fall_in);
        logic [W-1:0] mhz, hz, rise, fall;
        logic [W-1:0] t_low, t_high, t_dsu, t_dho, t_sta, t_sto;
        logic [W-1:0] divh, divl, total, bonus, hb, lim, step, s_sta, s_sto, upd;
        logic [W-1:0] v, su_ns, ho_ns;
        bit found;
        timing_res_t r;
        mhz = W'(mhz_in);
        hz = W'(hz_in);
        rise = W'(rise_in);
        fall = W'(fall_in);
        r = '0;
        lim = 0;
        upd = 0;
        found = 1'b0;
        if (hz == 0 || hz > i2ctdc_pkg::HZ_FPLUS_MAX || mhz == 0)
        begin
            r.error_code = i2ctdc_pkg::ERR_RATE;
            return r;
        end
        if (hz <= i2ctdc_pkg::HZ_STD_MAX)
        begin
            t_low = 4700; t_high = 4000; t_dsu = 250; t_dho = 3450; t_sta = 4700; t_sto = 4000;
        end
        else if (hz <= i2ctdc_pkg::HZ_FAST_MAX)
        begin
            t_low = 1300; t_high = 600; t_dsu = 100; t_dho = 900; t_sta = 600; t_sto = 600;
        end
        else
        begin
            t_low = 500; t_high = 260; t_dsu = 50; t_dho = 400; t_sta = 260; t_sto = 260;
        end
        divh = div_up((rise + t_high) * mhz, 8000);
        divl = div_up((fall + t_low) * mhz, 8000);
        total = div_up(mhz * 32'd125000, hz);
        if (divh + divl < total)
        begin
            bonus = total - divh - divl;
            hb = bonus / 2;
            divh = divh + hb;
            divl = divl + bonus - hb;
        end
        else
        begin
            hz = (mhz * 32'd125000) / (divl + divh);
            lim = 1;
        end
        if (divh > 32'h10000 || divl > 32'h10000)
        begin
            r.error_code = i2ctdc_pkg::ERR_OVF;
            return r;
        end
        step = 32'd8000 * divh;
        s_sta = div_up(mhz * (rise + t_sta) - 32'd1000, step);
        s_sto = div_up(mhz * (rise + t_sto) - 32'd1000, step);
        if (s_sta >= 4 || s_sto >= 4)
        begin
            r.error_code = i2ctdc_pkg::ERR_SETUP;
            return r;
        end
        for (int i = 0; i < 6 && !found; i++)
        begin
            v = 5 - i;
            su_ns = (((8 - v) * divl + 1) * 32'd1000) / mhz;
            ho_ns = div_up((v * divl + 1) * 32'd1000, mhz);
            if (ho_ns <= t_dho && su_ns >= t_dsu)
            begin
                upd = v;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            r.error_code = i2ctdc_pkg::ERR_HOLD;
            return r;
        end
        r.control_word = 16'((s_sta << 12) | (s_sto << 14) | (upd << 8));
        r.divider_word = ((divh - 1) << 16) | (divl - 1);
        r.effective_hz = hz[19:0];
        r.rate_limited = lim[0];
        r.error_code = i2ctdc_pkg::ERR_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic send_params(input logic [9:0] mhz, input logic [19:0] hz,
                               input logic [11:0] rise, input logic [11:0] fall);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.controller_mhz <= mhz;
        req.target_hz <= hz;
        req.rise_time_ns <= rise;
        req.fall_time_ns <= fall;
        expected_timings.push_back(calc_timing(mhz, hz, rise, fall));
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic finish_sending();
        req.valid <= 1'b0;
        wait (expected_timings.size() == 0);
        repeat (600) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        timing_res_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_timings.size() == 0)
                report_mismatch("unexpected item", 0, 0);
            else
            begin
                want = expected_timings.pop_front();
                if (rsp.control_word !== want.control_word)
                    report_mismatch("control_word", rsp.control_word, want.control_word);
                if (rsp.divider_word !== want.divider_word)
                    report_mismatch("divider_word", rsp.divider_word, want.divider_word);
                if (rsp.effective_hz !== want.effective_hz)
                    report_mismatch("effective_hz", rsp.effective_hz, want.effective_hz);
                if (rsp.rate_limited !== want.rate_limited)
                    report_mismatch("rate_limited", rsp.rate_limited, want.rate_limited);
                if (rsp.error_code !== want.error_code)
                    report_mismatch("error_code", rsp.error_code, want.error_code);
            end
        end
    end

    // The receiver idles in short bursts, or holds off for a long stretch on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
                rsp.ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_params(10'd100, 20'd100000, 12'd0, 12'd0);
        send_params(10'd100, 20'd400000, 12'd300, 12'd300);
        send_params(10'd100, 20'd1000000, 12'd120, 12'd120);
        send_params(10'd1, 20'd1, 12'd0, 12'd0);
        send_params(10'd1023, 20'd1000000, 12'd4095, 12'd4095);
        send_params(10'd1023, 20'd1, 12'd4095, 12'd4095);
        send_params(10'd0, 20'd100000, 12'd100, 12'd100);
        send_params(10'd50, 20'd0, 12'd100, 12'd100);
        send_params(10'd50, 20'd1000001, 12'd100, 12'd100);
        send_params(10'd1023, 20'hFFFFF, 12'hFFF, 12'hFFF);
        send_params(10'd200, 20'd1000000, 12'd4095, 12'd4095);
        send_params(10'd1, 20'd1000000, 12'd0, 12'd0);
        send_params(10'd2, 20'd400000, 12'd0, 12'd0);
        send_params(10'd8, 20'd100001, 12'd1000, 12'd10);
        send_params(10'd24, 20'd100000, 12'd1000, 12'd1000);
        send_params(10'd600, 20'd100, 12'd50, 12'd50);
        send_params(10'd3, 20'd50000, 12'd4095, 12'd0);
        send_params(10'd1, 20'd400001, 12'd0, 12'd4095);
        finish_sending();
    endtask

    task automatic test_random(input int count);
        logic [9:0] mhz;
        logic [19:0] hz;
        for (int n = 0; n < count; n++)
        begin
            mhz = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 200));
            case ($urandom_range(0, 4))
                0: hz = 20'($urandom);
                1: hz = 20'($urandom_range(1, 100000));
                2: hz = 20'($urandom_range(100001, 400000));
                default: hz = 20'($urandom_range(400001, 1000000));
            endcase
            send_params(mhz, hz, 12'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 400)),
                        12'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 400)));
        end
        finish_sending();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 12; n++)
            send_params(10'($urandom_range(1, 100)), 20'($urandom_range(1, 1000000)),
                        12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
        finish_sending();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(480);
        test_backpressure();
        idle_enable = 1'b0;
        test_random(150);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/i2ctdc_pkg.sv
hdl/i2ctdc_if.sv
hdl/i2ctdc_div.sv
hdl/i2ctdc_dpath.sv
hdl/i2ctdc_ctrl.sv
hdl/i2c_timing_divider_calc_core.sv
tb/tb.sv
